### rtl/tsc_pkg.sv
// Shared types, constants and the CRC-8 byte update for the scratchpad checker.
package tsc_pkg;

    // Bytes in one scratchpad frame, the CRC check byte being the last
    localparam int FRAME_BYTES = 9;
    localparam logic [3:0] LAST_POS = 4'(FRAME_BYTES - 1);

    // Reflected CRC-8 polynomial
    localparam logic [7:0] CRC_POLY = 8'h8C;

    // Item kinds on the input side
    localparam logic KIND_PRESENCE = 1'b0;
    localparam logic KIND_DATA     = 1'b1;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NO_PRESENCE  = 2'd1,
        ST_CRC_BAD      = 2'd2,
        ST_DISCONNECTED = 2'd3
    } status_t;

    // One registered input item
    typedef struct packed {
        logic       kind;
        logic       present;
        logic [7:0] data;
    } item_t;

    // One result item
    typedef struct packed {
        status_t            status;
        logic signed [15:0] temp;
    } result_t;

    // Byte-wide CRC-8 update, least significant bit first
    function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] b);
        logic [7:0] crc;
        logic       fb;
        crc = crc_in;
        for (int i = 0; i < 8; i++) begin
            fb  = crc[0] ^ b[i];
            crc = {1'b0, crc[7:1]};
            if (fb)
            begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

endpackage

### rtl/tsc_in_stage.sv
// Input register: captures one item per cycle while ready, holds it until processed.
module tsc_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [15:0]   s_tdata,   // [0] sensor_present, [8:1] data_byte, [15:9] zero
    input  logic          s_tuser,   // [0] kind
    input  logic          advance,
    output logic          item_valid,
    output tsc_pkg::item_t item
);
    import tsc_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // Free when empty or when the held item moves on this cycle
    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.kind    <= s_tuser;
            item_reg.present <= s_tdata[0];
            item_reg.data    <= s_tdata[8:1];
        end
    end

endmodule

### rtl/tsc_frame.sv
// Frame tracking: CRC, byte position and temperature capture, and the status decision.
module tsc_frame (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  tsc_pkg::item_t   item,
    output logic             res_valid,
    output tsc_pkg::result_t res
);
    import tsc_pkg::*;

    logic [7:0] crc_reg,  crc_next;
    logic [3:0] pos_reg,  pos_next;
    logic       open_reg, open_next;
    logic [7:0] lo_reg,   lo_next;
    logic [7:0] hi_reg,   hi_next;
    logic [15:0] raw;

    assign raw = {hi_reg, lo_reg};

    // Next frame state and the result of the item being processed
    always_comb
    begin
        crc_next   = crc_reg;
        pos_next   = pos_reg;
        open_next  = open_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        res_valid  = 1'b0;
        res.status = ST_OK;
        res.temp   = '0;
        if (fire)
        begin
            if (item.kind == KIND_PRESENCE)
            begin
                // Presence aborts any frame and starts afresh
                crc_next  = '0;
                pos_next  = '0;
                lo_next   = '0;
                hi_next   = '0;
                open_next = item.present;
                if (!item.present)
                begin
                    res_valid  = 1'b1;
                    res.status = ST_NO_PRESENCE;
                end
            end
            else if (open_reg)
            begin
                if (pos_reg < LAST_POS)
                begin
                    crc_next = crc_byte(crc_reg, item.data);
                    if (pos_reg == 4'd0)
                    begin
                        lo_next = item.data;
                    end
                    else if (pos_reg == 4'd1)
                    begin
                        hi_next = item.data;
                    end
                    pos_next = pos_reg + 4'd1;
                end
                else
                begin
                    // Check byte: close the frame and report
                    open_next = 1'b0;
                    pos_next  = '0;
                    res_valid = 1'b1;
                    priority if (crc_reg != item.data)
                    begin
                        res.status = ST_CRC_BAD;
                    end
                    else if (raw == 16'hFFFF || raw == 16'h0000)
                    begin
                        res.status = ST_DISCONNECTED;
                    end
                    else
                    begin
                        res.status = ST_OK;
                        res.temp   = signed'(raw);
                    end
                end
            end
        end
    end

    // Frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= '0;
            pos_reg  <= '0;
            open_reg <= 1'b0;
            lo_reg   <= '0;
            hi_reg   <= '0;
        end
        else
        begin
            crc_reg  <= crc_next;
            pos_reg  <= pos_next;
            open_reg <= open_next;
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
        end
    end

    // Position never runs past the check byte
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_POS)
        else $error("byte position beyond frame");

    // A closed frame always sits at position zero
    a_closed_pos: assert property (@(posedge clk) disable iff (!rst_n)
        !open_reg |-> pos_reg == 4'd0)
        else $error("position nonzero with no frame open");

    // An ok result never carries a disconnected reading
    a_ok_temp: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status == ST_OK) |-> (res.temp != 16'sd0 && res.temp != -16'sd1))
        else $error("ok status with disconnected reading");

    // Data bytes with no frame open leave the state alone
    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.kind == KIND_DATA && !open_reg) |=> $stable(crc_reg) && !open_reg)
        else $error("state changed by a stray data byte");

endmodule

### rtl/temp_scratchpad_checker.sv
// A result item is registered as the item that causes it leaves the input register.
// Throughput: one input item per cycle; an input register and a result register
// separate the two sides, so a waiting result stops the input only once the input
// register also holds an item.
// A data item passes one byte-wide CRC-8 update, or the status compare as check byte.
// Reset (rst_n, asynchronous, active low) clears the CRC, position, captured bytes,
// closes any frame and empties both registers.
module temp_scratchpad_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [0] sensor_present, [8:1] data_byte, [15:9] zero
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [1:0] status, [17:2] temperature_raw, [23:18] zero
);
    import tsc_pkg::*;

    logic    advance;
    logic    item_valid;
    item_t   item;
    logic    res_valid;
    result_t res;
    logic    out_valid_reg;
    result_t out_reg;

    // The held item moves on when the result register is free or being emptied
    assign advance = !out_valid_reg || m_tready;

    tsc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    tsc_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (item_valid && advance),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_valid;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.temp, out_reg.status};

endmodule
